// ===== hdl/assert_macros.svh =====
// Assertion helpers for the pump sequencer RTL.
// Expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PPRBS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define PPRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pprbs_pkg.sv =====
// Shared types, codes and constants of the pump sequencer.
// No dependencies; used by every module in hdl.
`timescale 1ns / 1ps
`default_nettype none

package pprbs_pkg;

	localparam int SecW     = 15;
	localparam int ElapsedW = 16;
	localparam int CfgIdxW  = 2;

	localparam logic [ElapsedW-1:0] ElapsedTop = '1;
	localparam logic [SecW-1:0]     TimeoutRst = SecW'(120);

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_PRIME    = 3'd1,
		MODE_RUNNING  = 3'd2,
		MODE_BLOWOFF  = 3'd3,
		MODE_MIXING   = 3'd4,
		MODE_DISABLED = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_START   = 3'd1,
		KIND_STOP    = 3'd2,
		KIND_DISABLE = 3'd3,
		KIND_MIX     = 3'd4
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ENABLED_AT_RESET = 2'd0,
		REG_PRIME_SECONDS    = 2'd1,
		REG_BLOWOFF_SECONDS  = 2'd2,
		REG_PUMP_TIMEOUT     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SecW-1:0] prime_seconds;
		logic [SecW-1:0] blowoff_seconds;
		logic [SecW-1:0] pump_timeout_seconds;
	} cfg_t;

	typedef struct packed {
		logic [2:0]      kind;
		logic            reenable;
		logic [SecW-1:0] mix_seconds;
	} item_t;

	typedef struct packed {
		mode_t               mode;
		logic [ElapsedW-1:0] elapsed;
		logic [SecW-1:0]     run_limit;
		logic                enabled;
	} seq_state_t;

	typedef struct packed {
		logic  pump_on;
		logic  bypass_on;
		logic  enabled;
		mode_t mode;
	} result_t;

	// drive pattern of each mode
	function automatic logic mode_pump(mode_t m);
		return (m == MODE_PRIME) || (m == MODE_RUNNING) || (m == MODE_MIXING);
	endfunction

	function automatic logic mode_bypass(mode_t m);
		return (m == MODE_PRIME) || (m == MODE_BLOWOFF) || (m == MODE_MIXING);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pprbs_step.sv =====
// Next-state and result logic for one beat of the pump sequencer.
// Purely combinational; depends on pprbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pprbs_step (
	input  var pprbs_pkg::seq_state_t cur,
	input  var pprbs_pkg::cfg_t       cfg,
	input  var pprbs_pkg::item_t      item,
	output pprbs_pkg::seq_state_t     nxt,
	output pprbs_pkg::result_t        res
);
	import pprbs_pkg::*;

	logic [ElapsedW-1:0] elapsed_inc;
	logic                enter;
	mode_t               enter_mode;
	logic                en_cmd;
	logic                run_done;
	logic                timed_out;

	assign elapsed_inc = (cur.elapsed == ElapsedTop) ? cur.elapsed
		: cur.elapsed + ElapsedW'(1);
	assign run_done  = (|cur.run_limit) && (elapsed_inc > {1'b0, cur.run_limit});
	assign timed_out = elapsed_inc > {1'b0, cfg.pump_timeout_seconds};
	assign en_cmd    = cur.enabled | item.reenable;

	always_comb begin
		nxt        = cur;
		enter      = 1'b0;
		enter_mode = cur.mode;
		case (item.kind)
			KIND_TICK: begin
				nxt.elapsed = elapsed_inc;
				case (cur.mode)
					MODE_PRIME: begin
						if (elapsed_inc > {1'b0, cfg.prime_seconds}) begin
							enter      = 1'b1;
							enter_mode = MODE_RUNNING;
						end
					end
					MODE_RUNNING: begin
						if (run_done) begin
							nxt.run_limit = '0;
							enter         = 1'b1;
							enter_mode    = (|cfg.blowoff_seconds) ? MODE_BLOWOFF : MODE_IDLE;
						end else if (timed_out) begin
							enter      = 1'b1;
							enter_mode = MODE_DISABLED;
						end
					end
					MODE_BLOWOFF: begin
						if (elapsed_inc > {1'b0, cfg.blowoff_seconds}) begin
							enter      = 1'b1;
							enter_mode = MODE_IDLE;
						end
					end
					MODE_MIXING: begin
						if (run_done || timed_out) begin
							nxt.run_limit = '0;
							enter         = 1'b1;
							enter_mode    = MODE_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			KIND_START: begin
				nxt.enabled = en_cmd;
				enter       = en_cmd;
				enter_mode  = (|cfg.prime_seconds) ? MODE_PRIME : MODE_RUNNING;
			end
			KIND_STOP: begin
				nxt.enabled = en_cmd;
				enter       = en_cmd;
				enter_mode  = (|cfg.blowoff_seconds) ? MODE_BLOWOFF : MODE_IDLE;
			end
			KIND_DISABLE: begin
				enter      = 1'b1;
				enter_mode = MODE_DISABLED;
			end
			KIND_MIX: begin
				if (|item.mix_seconds) begin
					nxt.run_limit = item.mix_seconds;
				end
				enter      = 1'b1;
				enter_mode = MODE_MIXING;
			end
			default: begin
			end
		endcase

		// every mode entry restarts the seconds count
		if (enter) begin
			nxt.mode    = enter_mode;
			nxt.elapsed = '0;
			if (enter_mode == MODE_DISABLED) begin
				nxt.enabled = 1'b0;
			end
		end

		res.pump_on   = mode_pump(nxt.mode);
		res.bypass_on = mode_bypass(nxt.mode);
		res.enabled   = nxt.enabled;
		res.mode      = nxt.mode;
	end

endmodule

`default_nettype wire

// ===== hdl/pprbs_out_buf.sv =====
// Two-entry output register with skid slot for result beats.
// Depends on pprbs_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module pprbs_out_buf (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  var pprbs_pkg::result_t  in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output pprbs_pkg::result_t      out_data
);
	import pprbs_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    push;
	logic    pop;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign push      = in_valid && in_ready;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			// refill the output slot, skid first
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pump_prime_run_blowoff_sequencer.sv =====
// Top level of the pump and bypass-valve sequencer.
// Depends on pprbs_pkg, pprbs_step, pprbs_out_buf and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Pump and bypass-valve sequencer. Each input beat is a one-second tick or a
// command (start, stop, disable, mix); each accepted beat yields exactly one
// result beat carrying the pump drive, bypass drive, enable flag and mode as
// they stand after that beat. Rate: one beat per clock while the master
// side keeps up. The whole update is a single pass of logic from the state
// registers to the next state and result, and the result is registered in
// the output stage. A two-entry output stage lets the slave side keep
// taking beats while one result waits; s_tready drops only once two results
// are pending. After reset the pump comes up idle and enabled, all counters
// clear, prime and blow-off times are zero (both phases skipped) and the
// pump timeout is 120 s. The user must write configuration through cfg_*
// only while no beat is in flight; the block does not enforce this. The
// enable-at-reset register (index 0) is accepted and has no further effect,
// as reset always restores enabled. Elapsed seconds saturate at 65535; a
// phase ends once the count is strictly greater than its limit.

module pump_prime_run_blowoff_sequencer (
	input  wire                           clk,
	input  wire                           arst_n,
	// slave side
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [15:0]                   s_tdata,  // [0] reenable, [15:1] mix_seconds
	input  wire  [2:0]                    s_tuser,  // [2:0] kind
	// master side
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [7:0]                    m_tdata,  // [0] pump_on, [1] bypass_on,
	                                                // [2] enabled, [5:3] mode, [7:6] zero
	// configuration
	input  wire                           cfg_wr_en,
	input  wire  [pprbs_pkg::CfgIdxW-1:0] cfg_index,
	input  wire  [pprbs_pkg::SecW-1:0]    cfg_wdata
);
	`include "assert_macros.svh"
	import pprbs_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	item_t      item;
	result_t    res;
	result_t    out_res;
	logic       in_fire;

	// unpack the slave beat
	assign item.kind        = s_tuser;
	assign item.reenable    = s_tdata[0];
	assign item.mix_seconds = s_tdata[15:1];

	assign in_fire = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prime_seconds        <= '0;
			cfg_q.blowoff_seconds      <= '0;
			cfg_q.pump_timeout_seconds <= TimeoutRst;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PRIME_SECONDS:    cfg_q.prime_seconds        <= cfg_wdata;
				REG_BLOWOFF_SECONDS:  cfg_q.blowoff_seconds      <= cfg_wdata;
				REG_PUMP_TIMEOUT:     cfg_q.pump_timeout_seconds <= cfg_wdata;
				default: begin
					// enable-at-reset: reset always restores enabled
				end
			endcase
		end
	end

	pprbs_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item),
		.nxt  (state_nxt),
		.res  (res)
	);

	// sequencer state: advance on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= MODE_IDLE;
			state_q.elapsed   <= '0;
			state_q.run_limit <= '0;
			state_q.enabled   <= 1'b1;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	pprbs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {2'b00, out_res.mode, out_res.enabled, out_res.bypass_on, out_res.pump_on};

	// disabled mode always carries a cleared enable flag
	`PPRBS_ASSERT_IMPL(a_disabled_flag, state_q.mode == MODE_DISABLED, !state_q.enabled, "disabled mode with enable flag set")
	// an accepted disable lands in disabled with the count restarted
	`PPRBS_ASSERT_NEXT(a_disable_cmd, in_fire && (s_tuser == KIND_DISABLE), (state_q.mode == MODE_DISABLED) && (state_q.elapsed == '0), "disable beat not applied")
	// backpressure only with results pending downstream
	`PPRBS_ASSERT_IMPL(a_stall_has_data, !s_tready, m_tvalid, "slave stalled with no result pending")
	// an accepted beat always leaves a result waiting
	`PPRBS_ASSERT_NEXT(a_result_follows, in_fire, m_tvalid, "accepted beat produced no result")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the pump and bypass-valve sequencer.
// Depends on pprbs_pkg and pump_prime_run_blowoff_sequencer from hdl.
`timescale 1ns / 1ps

module tb;

	import pprbs_pkg::*;

	// kinds with no meaning; the block must report status and change nothing
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam int CycleLimit = 2_000_000;
	localparam int HoldOffCycles = 300;
	localparam int PhaseBeats = 48;
	localparam int RandomPhases = 9;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [0] reenable, [15:1] mix_seconds
	logic [2:0]  s_tuser = '0;  // [2:0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // [0] pump_on, [1] bypass_on, [2] enabled, [5:3] mode

	logic               cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [SecW-1:0]    cfg_wdata = '0;

	pump_prime_run_blowoff_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the sequencer: settings and state as the block should
	// hold them. Reset always comes up idle and enabled, since the
	// enable-at-reset setting is still at its reset value of 1 when the
	// one and only reset is applied; later writes to it change nothing.
	// ------------------------------------------------------------------
	logic            shadow_en_at_reset = 1'b1;
	logic [SecW-1:0] shadow_prime = '0;
	logic [SecW-1:0] shadow_blowoff = '0;
	logic [SecW-1:0] shadow_timeout = TimeoutRst;

	mode_t               seq_mode = MODE_IDLE;
	logic [ElapsedW-1:0] seq_secs = '0;
	logic [SecW-1:0]     seq_limit = '0;
	logic                seq_enabled = 1'b1;

	item_t   cmd_queue[$];        // beats waiting to go out on the slave side
	result_t status_expected[$];  // predicted status beats, oldest first

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	int  gap_left = 0;
	int  hold_left = 0;
	int  style_left = 0;
	int  rx_style = 0;
	bit  sender_steady = 1'b0;  // no gaps between bursts
	bit  rx_eager = 1'b0;       // receiver keeps to its lighter stall styles
	bit  hold_off_go = 1'b0;    // one-cycle request for a long receiver stall
	item_t drv_cmd;

	// Every entry to a mode, re-entry included, restarts the seconds count;
	// entering disabled also drops the enable flag.
	function automatic void enter_seq_mode(mode_t m);
		seq_mode = m;
		seq_secs = '0;
		if (m == MODE_DISABLED)
			seq_enabled = 1'b0;
	endfunction

	// Apply one accepted beat to the shadow and return the status it yields.
	function automatic result_t advance_sequencer(item_t c);
		result_t r;
		case (c.kind)
			KIND_TICK: begin
				if (seq_secs != ElapsedTop)
					seq_secs = seq_secs + 1'b1;
				case (seq_mode)
					MODE_PRIME: begin
						if (seq_secs > shadow_prime)
							enter_seq_mode(MODE_RUNNING);
					end
					MODE_RUNNING: begin
						// the run limit wins over the safety timeout
						if (seq_limit != 0 && seq_secs > seq_limit) begin
							seq_limit = '0;
							enter_seq_mode(shadow_blowoff != 0 ? MODE_BLOWOFF : MODE_IDLE);
						end else if (seq_secs > shadow_timeout) begin
							enter_seq_mode(MODE_DISABLED);
						end
					end
					MODE_BLOWOFF: begin
						if (seq_secs > shadow_blowoff)
							enter_seq_mode(MODE_IDLE);
					end
					MODE_MIXING: begin
						if ((seq_limit != 0 && seq_secs > seq_limit) ||
						    seq_secs > shadow_timeout) begin
							seq_limit = '0;
							enter_seq_mode(MODE_IDLE);
						end
					end
					default: ;
				endcase
			end
			KIND_START: begin
				if (c.reenable)
					seq_enabled = 1'b1;
				if (seq_enabled)
					enter_seq_mode(shadow_prime != 0 ? MODE_PRIME : MODE_RUNNING);
			end
			KIND_STOP: begin
				if (c.reenable)
					seq_enabled = 1'b1;
				if (seq_enabled)
					enter_seq_mode(shadow_blowoff != 0 ? MODE_BLOWOFF : MODE_IDLE);
			end
			KIND_DISABLE: begin
				enter_seq_mode(MODE_DISABLED);
			end
			KIND_MIX: begin
				// a zero run time keeps the old limit; the enable flag is untouched
				if (c.mix_seconds != 0)
					seq_limit = c.mix_seconds;
				enter_seq_mode(MODE_MIXING);
			end
			default: ;
		endcase
		r.pump_on   = seq_mode inside {MODE_PRIME, MODE_RUNNING, MODE_MIXING};
		r.bypass_on = seq_mode inside {MODE_PRIME, MODE_BLOWOFF, MODE_MIXING};
		r.enabled   = seq_enabled;
		r.mode      = seq_mode;
		return r;
	endfunction

	// One line per mismatch; the count decides the verdict. Printing stops
	// after a few dozen lines to keep the log readable.
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps between them. Hold the
	// beat until it is taken, then advance to the next pending one.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (cmd_queue.size() != 0) begin
				drv_cmd = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_cmd.kind;
				s_tdata <= {drv_cmd.mix_seconds, drv_cmd.reenable};
				if (burst_left <= 1) begin
					// start a new burst; schedule the gap that follows it
					burst_left <= $urandom_range(1, 16);
					if (sender_steady || $urandom_range(0, 2) == 0)
						gap_left <= 0;
					else
						gap_left <= $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: a stall style that is drawn anew each time its countdown runs
	// out, plus a long hold-off on request so that the output stage fills and
	// the block pushes back on the slave side.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			rx_style <= 0;
			style_left <= 0;
		end else begin
			if (style_left == 0) begin
				rx_style <= rx_eager ? $urandom_range(0, 1) : $urandom_range(0, 3);
				style_left <= $urandom_range(16, 96);
			end else begin
				style_left <= style_left - 1;
			end
			if (hold_off_go) begin
				hold_left <= HoldOffCycles;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				case (rx_style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on every accepted input beat, then check every
	// accepted output beat against the oldest prediction. Both are done
	// in one process so the order of the two within a step is fixed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		item_t   seen;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.kind = s_tuser;
				seen.reenable = s_tdata[0];
				seen.mix_seconds = s_tdata[15:1];
				status_expected.push_back(advance_sequencer(seen));
			end
			if (m_tvalid && m_tready) begin
				if (status_expected.size() == 0) begin
					report_mismatch("status beat with nothing pending, data", m_tdata, 0);
				end else begin
					want = status_expected.pop_front();
					if (m_tdata[0] !== want.pump_on)
						report_mismatch("pump_on", m_tdata[0], want.pump_on);
					if (m_tdata[1] !== want.bypass_on)
						report_mismatch("bypass_on", m_tdata[1], want.bypass_on);
					if (m_tdata[2] !== want.enabled)
						report_mismatch("enabled", m_tdata[2], want.enabled);
					if (m_tdata[5:3] !== want.mode)
						report_mismatch("mode", m_tdata[5:3], want.mode);
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_cmd(input logic [2:0] kind, input logic reen,
	                        input logic [SecW-1:0] secs);
		item_t c;
		c.kind = kind;
		c.reenable = reen;
		c.mix_seconds = secs;
		cmd_queue.push_back(c);
	endtask

	// Ticks carry random junk in the fields they ignore.
	task automatic push_ticks(input int n);
		repeat (n)
			push_cmd(KIND_TICK, $urandom_range(0, 1), SecW'($urandom));
	endtask

	// Write one register; only called while nothing is in flight.
	task automatic write_reg(input cfg_reg_t idx, input logic [SecW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_ENABLED_AT_RESET: shadow_en_at_reset = val[0];
			REG_PRIME_SECONDS:    shadow_prime = val;
			REG_BLOWOFF_SECONDS:  shadow_blowoff = val;
			default:              shadow_timeout = val;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all_regs(input logic en, input logic [SecW-1:0] prime,
	                              input logic [SecW-1:0] blowoff,
	                              input logic [SecW-1:0] timeout);
		write_reg(REG_ENABLED_AT_RESET, SecW'(en));
		write_reg(REG_PRIME_SECONDS, prime);
		write_reg(REG_BLOWOFF_SECONDS, blowoff);
		write_reg(REG_PUMP_TIMEOUT, timeout);
	endtask

	// Block until every queued beat has gone out and every status is back.
	// Sampled at the falling edge, clear of the clocked updates.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || status_expected.size() != 0);
	endtask

	// Short durations mostly, so that phases actually expire; now and then
	// zero, the top value or anything at all.
	function automatic logic [SecW-1:0] pick_seconds(input bit allow_zero);
		logic [SecW-1:0] v;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			v = allow_zero ? '0 : SecW'(1);
		else if (roll < 8)
			v = SecW'($urandom_range(1, 6));
		else if (roll == 8)
			v = SecW'($urandom);
		else
			v = '1;
		if (!allow_zero && v == 0)
			v = SecW'(1);
		return v;
	endfunction

	function automatic logic [SecW-1:0] pick_mix_seconds();
		return ($urandom_range(0, 3) == 0) ? SecW'($urandom) : SecW'($urandom_range(0, 12));
	endfunction

	// Mostly well-formed start/run/stop and mix sequences with random
	// timing, the rest loose commands, spare kinds included.
	task automatic queue_random_traffic(input int n);
		int base;
		int unsigned roll;
		base = cmd_queue.size();
		while (cmd_queue.size() - base < n) begin
			roll = $urandom_range(0, 9);
			if (roll < 5) begin
				push_cmd(KIND_START, $urandom_range(0, 1), SecW'($urandom));
				push_ticks($urandom_range(0, 12));
				push_cmd(KIND_STOP, $urandom_range(0, 1), SecW'($urandom));
				push_ticks($urandom_range(0, 8));
			end else if (roll < 7) begin
				push_cmd(KIND_MIX, $urandom_range(0, 1), pick_mix_seconds());
				push_ticks($urandom_range(0, 14));
			end else if (roll == 7) begin
				push_cmd(KIND_DISABLE, $urandom_range(0, 1), SecW'($urandom));
				push_ticks($urandom_range(0, 3));
			end else begin
				case ($urandom_range(0, 5))
					0: push_cmd(KIND_START, $urandom_range(0, 1), SecW'($urandom));
					1: push_cmd(KIND_STOP, $urandom_range(0, 1), SecW'($urandom));
					2: push_cmd(KIND_MIX, $urandom_range(0, 1), pick_mix_seconds());
					3: push_cmd(KIND_DISABLE, $urandom_range(0, 1), SecW'($urandom));
					4: push_cmd(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
					            $urandom_range(0, 1), SecW'($urandom));
					default: push_ticks($urandom_range(1, 4));
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: prime and blow-off skipped, timeout 120.
		// Refused start and stop while disabled, mix while disabled,
		// re-enable, spare kinds with all field bits set, both mix extremes.
		push_cmd(KIND_TICK, 1'b0, '0);
		push_cmd(KIND_START, 1'b0, '0);
		push_cmd(KIND_TICK, 1'b1, '1);
		push_cmd(KIND_STOP, 1'b0, '0);
		push_cmd(KIND_DISABLE, 1'b1, '1);
		push_cmd(KIND_START, 1'b0, '1);
		push_cmd(KIND_TICK, 1'b0, '0);
		push_cmd(KIND_STOP, 1'b0, '0);
		push_cmd(KIND_MIX, 1'b0, '0);
		push_cmd(KIND_START, 1'b1, '0);
		push_cmd(KIND_SPARE_LO, 1'b1, '1);
		push_cmd(KIND_SPARE_LO + 3'd1, 1'b1, '1);
		push_cmd(KIND_SPARE_HI, 1'b1, '1);
		push_cmd(KIND_MIX, 1'b1, '1);
		push_cmd(KIND_TICK, 1'b0, '0);
		push_cmd(KIND_MIX, 1'b0, SecW'(1));
		push_ticks(2);
		push_cmd(KIND_STOP, 1'b1, '0);
		wait_drained();

		// Short phases: a run limit left over from mix ends running into
		// blow-off; the safety timeout ends running into disabled.
		write_all_regs(1'b0, SecW'(2), SecW'(3), SecW'(4));
		push_cmd(KIND_MIX, 1'b0, SecW'(3));
		push_cmd(KIND_START, 1'b0, '0);
		push_ticks(11);
		push_cmd(KIND_START, 1'b0, '0);
		push_ticks(8);
		push_cmd(KIND_STOP, 1'b1, '0);
		push_ticks(4);
		wait_drained();

		// Timeout of zero: start enters priming (prime is still 2); the first tick after mix ends mixing.
		write_reg(REG_PUMP_TIMEOUT, '0);
		push_cmd(KIND_START, 1'b1, '0);
		push_cmd(KIND_TICK, 1'b0, '0);
		push_cmd(KIND_MIX, 1'b0, '0);
		push_cmd(KIND_TICK, 1'b0, '0);
		wait_drained();

		// Top durations: priming, blow-off, mix time and the timeout all at
		// the 15-bit top, so no phase expires here. Keep both sides busy.
		sender_steady = 1'b1;
		rx_eager = 1'b1;
		write_all_regs(1'b1, '1, '1, '1);
		push_cmd(KIND_START, 1'b1, '0);
		push_ticks(8);
		push_cmd(KIND_MIX, 1'b0, '1);
		push_ticks(6);
		push_cmd(KIND_STOP, 1'b1, '0);
		push_ticks(6);
		wait_drained();
		sender_steady = 1'b0;
		rx_eager = 1'b0;

		// Random phases, each with its own settings; the sender pauses at
		// every boundary until all status beats are back.
		for (int p = 0; p < RandomPhases; p++) begin
			write_all_regs($urandom_range(0, 1), pick_seconds(1'b1), pick_seconds(1'b1),
			               pick_seconds(1'b0));
			queue_random_traffic(PhaseBeats);
			if (p == 1) begin
				// long receiver hold-off while the sender keeps offering beats
				@(negedge clk);
				hold_off_go = 1'b1;
				@(negedge clk);
				hold_off_go = 1'b0;
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
